@@ hdl/coordinate_fit_relative_error_top_defines.svh @@
// Assertion macros shared by the coordinate fit cost block.
`ifndef COORDINATE_FIT_RELATIVE_ERROR_TOP_DEFINES_SVH
`define COORDINATE_FIT_RELATIVE_ERROR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CFRE_ASSERT_SAME(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("same-cycle check failed");
`define CFRE_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define CFRE_ASSERT_SAME(label, a, c)
`define CFRE_ASSERT_NEXT(label, a, c)
`endif
`endif

@@ hdl/cfre_pkg.sv @@
// Types and constants of the coordinate fit cost block.
package cfre_pkg;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned RTT_W   = 24;
    localparam int unsigned COST_W  = 48;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned SQ_W    = 53;

    typedef struct packed {
        logic signed [COORD_W-1:0] landmark_coord;
        logic signed [COORD_W-1:0] node_coord;
        logic        [RTT_W-1:0]   round_trip;
        logic                      last_dim;
        logic                      last_landmark;
    } in_word_t;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic               zero_rtt_seen;
        logic [COUNT_W-1:0] landmark_count;
    } out_word_t;
endpackage

@@ hdl/coordinate_fit_relative_error_top.sv @@
// Relative-error cost of a network coordinate fit, computed bit-serially.
//
// Input words arrive on in_valid/in_ready, one coordinate component each.
// Result words leave on out_valid/out_ready, one per word marked last_landmark.
// Every input word first runs a bit-serial square of the component difference
// plus an accumulate step; no next word is taken before it returns to idle.
// A word with last_dim set also runs a restoring square root, one root bit per
// cycle, a setup step, a restoring divide, one quotient bit per cycle, a serial
// square of the quotient and an add step.
// A word with last_landmark set adds an emit step that loads the output register.
// The output register lets the sequencer accept the next word while a result
// waits; it stalls only if a new result is ready while the old one is unread.
// Reset clears the square and cost sums, the flag, the count and the output valid.
// A zero round trip on a last_dim word skips the term and sets zero_rtt_seen in the result.
`include "coordinate_fit_relative_error_top_defines.svh"
module coordinate_fit_relative_error_top
    import cfre_pkg::*;
#(
    parameter int unsigned COST_FRAC_BITS = 24
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);
    localparam int unsigned MW  = COORD_W + 1;          // difference magnitude
    localparam int unsigned PW0 = 2 * MW;               // difference square
    localparam int unsigned RW  = (SQ_W + 1) / 2;       // root bits
    localparam int unsigned NW  = RW + 1;               // numerator bits
    localparam int unsigned QW  = NW + COST_FRAC_BITS;  // quotient bits
    localparam int unsigned PW  = COST_W + COST_FRAC_BITS;
    localparam int unsigned VW  = 2 * RW;
    localparam int unsigned SRW = RW + 3;               // root remainder
    localparam int unsigned CW  = $clog2(QW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_PREP = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_SQR  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [MW-1:0]      mag_reg, mag_next;
    logic [MW-1:0]      mcand_reg, mcand_next;
    logic [PW0-1:0]     prod_reg, prod_next;
    logic [RTT_W-1:0]   rtt_reg, rtt_next;
    logic               ldim_reg, ldim_next;
    logic               lland_reg, lland_next;
    logic [SQ_W-1:0]    ss_reg, ss_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic               zero_reg, zero_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VW-1:0]      sv_reg, sv_next;
    logic [SRW-1:0]     srem_reg, srem_next;
    logic [RW-1:0]      root_reg, root_next;
    logic [QW-1:0]      dvd_reg, dvd_next;
    logic [RTT_W-1:0]   drem_reg, drem_next;
    logic [QW-1:0]      r_reg, r_next;
    logic [PW-1:0]      sq_reg, sq_next;
    logic               ovf_reg, ovf_next;
    logic               ovalid_reg, ovalid_next;
    out_word_t          oword_reg, oword_next;

    logic signed [MW-1:0] diff;
    logic [SQ_W:0]        ss_sum;
    logic [SRW-1:0]       srem4, strial;
    logic [NW-1:0]        dist2, num;
    logic [RTT_W:0]       drem2;
    logic [PW+1:0]        sq_sum;
    logic [COST_W:0]      cost_sum;
    logic [COST_W-1:0]    term;
    logic [3:0]           after_term;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_word  = oword_reg;

    // Datapath pieces of the serial steps.
    always_comb
    begin
        diff     = MW'(in_word.landmark_coord) - MW'(in_word.node_coord);
        ss_sum   = (SQ_W+1)'(ss_reg) + (SQ_W+1)'(prod_reg);
        srem4    = {srem_reg[SRW-3:0], sv_reg[VW-1 -: 2]};
        strial   = SRW'({root_reg, 2'b01});
        dist2    = {root_reg, 1'b0};
        num      = (NW'(rtt_reg) > dist2) ? NW'(rtt_reg) - dist2 : dist2 - NW'(rtt_reg);
        drem2    = {drem_reg, dvd_reg[QW-1]};
        sq_sum   = (PW+2)'({sq_reg, 1'b0}) + (dvd_reg[QW-1] ? (PW+2)'(r_reg) : '0);
        term     = ovf_reg ? {COST_W{1'b1}} : sq_reg[PW-1:COST_FRAC_BITS];
        cost_sum = (COST_W+1)'(cost_reg) + (COST_W+1)'(term);
        after_term = lland_reg ? S_EMIT : S_IDLE;
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mag_next    = mag_reg;
        mcand_next  = mcand_reg;
        prod_next   = prod_reg;
        rtt_next    = rtt_reg;
        ldim_next   = ldim_reg;
        lland_next  = lland_reg;
        ss_next     = ss_reg;
        cost_next   = cost_reg;
        zero_next   = zero_reg;
        count_next  = count_reg;
        sv_next     = sv_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        dvd_next    = dvd_reg;
        drem_next   = drem_reg;
        r_next      = r_reg;
        sq_next     = sq_reg;
        ovf_next    = ovf_reg;
        oword_next  = oword_reg;
        ovalid_next = ovalid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next   = diff[MW-1] ? MW'(-diff) : MW'(diff);
                    mcand_next = diff[MW-1] ? MW'(-diff) : MW'(diff);
                    prod_next  = '0;
                    cnt_next   = '0;
                    rtt_next   = in_word.round_trip;
                    ldim_next  = in_word.last_dim;
                    lland_next = in_word.last_landmark;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // One multiplier bit per cycle, most significant first.
                prod_next = {prod_reg[PW0-2:0], 1'b0} + (mag_reg[MW-1] ? PW0'(mcand_reg) : '0);
                mag_next  = {mag_reg[MW-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MW-1))
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                ss_next = ss_sum[SQ_W] ? {SQ_W{1'b1}} : ss_sum[SQ_W-1:0];
                if (!ldim_reg)
                    state_next = lland_reg ? S_EMIT : S_IDLE;
                else if (rtt_reg == '0)
                begin
                    zero_next  = 1'b1;
                    ss_next    = '0;
                    state_next = after_term;
                end
                else
                begin
                    sv_next    = VW'(ss_sum[SQ_W] ? {SQ_W{1'b1}} : ss_sum[SQ_W-1:0]);
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // Restoring square root, one root bit per cycle.
                sv_next  = {sv_reg[VW-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (srem4 >= strial)
                begin
                    srem_next = srem4 - strial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem4;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                if (cnt_reg == CW'(RW-1))
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                dvd_next   = {num, {COST_FRAC_BITS{1'b0}}};
                drem_next  = '0;
                cnt_next   = '0;
                ss_next    = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring divide; quotient bits shift in behind the dividend.
                cnt_next = cnt_reg + 1'b1;
                if (drem2 >= (RTT_W+1)'(rtt_reg))
                begin
                    drem_next = RTT_W'(drem2 - (RTT_W+1)'(rtt_reg));
                    dvd_next  = {dvd_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    drem_next = RTT_W'(drem2);
                    dvd_next  = {dvd_reg[QW-2:0], 1'b0};
                end
                if (cnt_reg == CW'(QW-1))
                begin
                    r_next     = {dvd_reg[QW-2:0], (drem2 >= (RTT_W+1)'(rtt_reg))};
                    sq_next    = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                // Square of the quotient, sticky overflow past the cost range.
                dvd_next = {dvd_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                sq_next  = sq_sum[PW-1:0];
                if (sq_sum[PW+1:PW] != 2'b00)
                    ovf_next = 1'b1;
                if (cnt_reg == CW'(QW-1))
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cost_next  = cost_sum[COST_W] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];
                if (count_reg != {COUNT_W{1'b1}})
                    count_next = count_reg + 1'b1;
                state_next = after_term;
            end
            S_EMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    oword_next.cost           = cost_reg;
                    oword_next.zero_rtt_seen  = zero_reg;
                    oword_next.landmark_count = count_reg;
                    ovalid_next = 1'b1;
                    ss_next     = '0;
                    cost_next   = '0;
                    zero_next   = 1'b0;
                    count_next  = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and accumulator registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ss_reg     <= '0;
            cost_reg   <= '0;
            zero_reg   <= 1'b0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ss_reg     <= ss_next;
            cost_reg   <= cost_next;
            zero_reg   <= zero_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Serial datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        rtt_reg   <= rtt_next;
        ldim_reg  <= ldim_next;
        lland_reg <= lland_next;
        sv_reg    <= sv_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        dvd_reg   <= dvd_next;
        drem_reg  <= drem_next;
        r_reg     <= r_next;
        sq_reg    <= sq_next;
        ovf_reg   <= ovf_next;
        oword_reg <= oword_next;
    end

    // An accepted word always starts the serial square.
    `CFRE_ASSERT_NEXT(a_accept_mul, in_valid && in_ready, state_reg == S_MUL)
    // A loaded result carries the count held before the clear.
    `CFRE_ASSERT_NEXT(a_emit_load, (state_reg == S_EMIT) && (!ovalid_reg || out_ready),
        ovalid_reg && (oword_reg.landmark_count == $past(count_reg)) && (count_reg == '0))
    // The square step counter never runs past the magnitude width.
    `CFRE_ASSERT_SAME(a_mul_cnt, state_reg == S_MUL, cnt_reg < CW'(MW))
endmodule
